// ----- rtl/pds_pkg.sv -----
// Package: shared constants, register codes and pipeline payload types for the pair switch.
`default_nettype none
package pds_pkg;

  // Coordinate width default and fixed field widths
  localparam int unsigned COORD_WIDTH_DEF = 32;
  localparam int unsigned RADIUS_W        = 31;
  localparam int unsigned FRAC_W          = 30;
  localparam int unsigned GRAD_W          = 32;
  localparam int unsigned CFG_IDX_W       = 2;

  // Fixed-point constants
  localparam logic [RADIUS_W-1:0] ONE_Q30      = RADIUS_W'(1) << FRAC_W;
  localparam logic [RADIUS_W-1:0] INNER_RESET  = RADIUS_W'(524288);
  localparam logic [RADIUS_W-1:0] OUTER_RESET  = RADIUS_W'(786432);

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_INNER = 2'd0,
    CFG_OUTER = 2'd1
  } cfg_idx_e;

  // Difference vector: sign and low magnitude bits of each component
  typedef struct packed {
    logic [2:0]                neg;
    logic [2:0][RADIUS_W-1:0]  mag;
  } vec_t;

  // Region flags and operands carried through the blend divider
  typedef struct packed {
    logic                 inner_hit;
    logic                 blend;
    logic [RADIUS_W-1:0]  span;
    logic [RADIUS_W-1:0]  dlen;
    vec_t                 vec;
  } mid_t;

  // Per-item results carried through the gradient divider
  typedef struct packed {
    logic                 inner_hit;
    logic                 blend;
    logic                 pneg;
    logic [RADIUS_W-1:0]  sw;
    logic [2:0]           neg;
    logic [2:0]           ovf;
  } tail_t;

endpackage
`default_nettype wire

// ----- rtl/pair_distance_switch.sv -----
// Top level: pipelined quintic switching factor and gradient of a pair distance.
//
//  channel   signals                                          direction  handshake
//  command   start_i, busy_o, first_*_i, second_*_i           in         start & !busy
//  result    done_o, switch_value_o, grad_x/y/z_o             out        done strobe
//  config    cfg_valid_i, cfg_ready_o, cfg_index_i, cfg_data_i in        valid & ready
//
// One item enters per cycle; busy_o stays low. Each item passes through 106 register
// stages to the result strobe: three input stages, 32 stages of the square-root chain,
// a classify stage, 30 stages of the x/y divider, six multiply stages, 33 stages of the
// gradient divider and the output register.
// Reset clears all valid bits and loads the radius reset values.
// No stalls: each result shows on the result ports for one cycle with done_o.
`default_nettype none
module pair_distance_switch #(
  parameter int unsigned COORD_WIDTH = pds_pkg::COORD_WIDTH_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              start_i,
  output logic                                   busy_o,
  input  wire logic signed [COORD_WIDTH-1:0]     first_x_i,
  input  wire logic signed [COORD_WIDTH-1:0]     first_y_i,
  input  wire logic signed [COORD_WIDTH-1:0]     first_z_i,
  input  wire logic signed [COORD_WIDTH-1:0]     second_x_i,
  input  wire logic signed [COORD_WIDTH-1:0]     second_y_i,
  input  wire logic signed [COORD_WIDTH-1:0]     second_z_i,
  output logic                                   done_o,
  output logic [pds_pkg::RADIUS_W-1:0]           switch_value_o,
  output logic signed [pds_pkg::GRAD_W-1:0]      grad_x_o,
  output logic signed [pds_pkg::GRAD_W-1:0]      grad_y_o,
  output logic signed [pds_pkg::GRAD_W-1:0]      grad_z_o,
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [pds_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  wire logic [pds_pkg::RADIUS_W-1:0]      cfg_data_i
);

  localparam int unsigned RW  = pds_pkg::RADIUS_W;
  localparam int unsigned FW  = pds_pkg::FRAC_W;
  localparam int unsigned MW  = COORD_WIDTH + 1;        // difference magnitude
  localparam int unsigned AW  = RW + 1;                 // clamped magnitude
  localparam int unsigned SW  = 2 * AW;                 // sum of squares
  localparam int unsigned DW  = AW;                     // root
  localparam int unsigned QG  = 33;                     // gradient quotient bits
  localparam int unsigned DNW = 2 * RW;                 // span * distance
  localparam int unsigned NMW = 69;                     // gradient numerator

  // Configuration registers
  logic [RW-1:0] inner_q, outer_q;

  assign cfg_ready_o = 1'b1;
  assign busy_o      = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inner_q <= pds_pkg::INNER_RESET;
      outer_q <= pds_pkg::OUTER_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        pds_pkg::CFG_INNER: inner_q <= cfg_data_i;
        pds_pkg::CFG_OUTER: outer_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Input stage: differences and magnitudes
  logic                     in_go;
  logic signed [MW-1:0]     diff   [3];
  logic [2:0][MW-1:0]       mag_d;
  logic [2:0][AW-1:0]       a_mag_d;
  logic                     a_vld_q;
  logic [2:0][AW-1:0]       a_mag_q;
  pds_pkg::vec_t            a_vec_q;
  pds_pkg::vec_t            a_vec_d;

  assign in_go = start_i && !busy_o;

  always_comb begin
    diff[0] = MW'(first_x_i) - MW'(second_x_i);
    diff[1] = MW'(first_y_i) - MW'(second_y_i);
    diff[2] = MW'(first_z_i) - MW'(second_z_i);
    for (int i = 0; i < 3; i++) begin
      mag_d[i]         = diff[i][MW-1] ? MW'(-diff[i]) : MW'(diff[i]);
      // Clamp at 2^31: the distance then lies beyond any outer radius
      a_mag_d[i]       = ((mag_d[i] >> RW) != '0) ? (AW'(1) << RW) : AW'(mag_d[i]);
      a_vec_d.neg[i]   = diff[i][MW-1];
      a_vec_d.mag[i]   = RW'(mag_d[i]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) a_vld_q <= 1'b0;
    else         a_vld_q <= in_go;
  end

  always_ff @(posedge clk_i) begin
    a_mag_q <= a_mag_d;
    a_vec_q <= a_vec_d;
  end

  // Square each component
  logic                 b_vld_q;
  logic [2:0][SW-1:0]   b_sq_q;
  pds_pkg::vec_t        b_vec_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) b_vld_q <= 1'b0;
    else         b_vld_q <= a_vld_q;
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      b_sq_q[i] <= SW'(a_mag_q[i]) * SW'(a_mag_q[i]);
    end
    b_vec_q <= a_vec_q;
  end

  // Sum the squares
  logic           c_vld_q;
  logic [SW-1:0]  c_sum_q;
  pds_pkg::vec_t  c_vec_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) c_vld_q <= 1'b0;
    else         c_vld_q <= b_vld_q;
  end

  always_ff @(posedge clk_i) begin
    c_sum_q <= b_sq_q[0] + b_sq_q[1] + b_sq_q[2];
    c_vec_q <= b_vec_q;
  end

  // Square root, one root bit per stage
  logic                sq_vld  [DW+1];
  logic [SW-1:0]       sq_rem  [DW+1];
  logic [DW-1:0]       sq_root [DW+1];
  pds_pkg::vec_t       sq_vec  [DW+1];

  assign sq_vld[0]  = c_vld_q;
  assign sq_rem[0]  = c_sum_q;
  assign sq_root[0] = '0;
  assign sq_vec[0]  = c_vec_q;

  for (genvar k = 0; k < DW; k++) begin : g_sqrt
    localparam int unsigned B = DW - 1 - k;
    logic [SW-1:0] trial;
    logic          take;
    logic          vld_q;
    logic [SW-1:0] rem_q;
    logic [DW-1:0] root_q;
    pds_pkg::vec_t vec_q;

    assign trial = (SW'(sq_root[k]) << (B + 1)) + (SW'(1) << (2 * B));
    assign take  = sq_rem[k] >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) vld_q <= 1'b0;
      else         vld_q <= sq_vld[k];
    end

    always_ff @(posedge clk_i) begin
      rem_q  <= take ? sq_rem[k] - trial : sq_rem[k];
      root_q <= take ? (sq_root[k] | (DW'(1) << B)) : sq_root[k];
      vec_q  <= sq_vec[k];
    end

    assign sq_vld[k+1]  = vld_q;
    assign sq_rem[k+1]  = rem_q;
    assign sq_root[k+1] = root_q;
    assign sq_vec[k+1]  = vec_q;
  end

  // Classify the distance and set up the blend numerators
  logic             d_vld_q;
  pds_pkg::mid_t    d_mid_q;
  logic [RW-1:0]    d_nx_q, d_ny_q;
  logic [DW-1:0]    root_len;
  logic             hit_in, hit_out;

  assign root_len = sq_root[DW];
  assign hit_in   = root_len <= DW'(inner_q);
  assign hit_out  = root_len >= DW'(outer_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) d_vld_q <= 1'b0;
    else         d_vld_q <= sq_vld[DW];
  end

  always_ff @(posedge clk_i) begin
    d_mid_q.inner_hit <= hit_in;
    d_mid_q.blend     <= !hit_in && !hit_out;
    d_mid_q.span      <= outer_q - inner_q;
    d_mid_q.dlen      <= root_len[RW-1:0];
    d_mid_q.vec       <= sq_vec[DW];
    d_nx_q            <= outer_q - root_len[RW-1:0];
    d_ny_q            <= root_len[RW-1:0] - inner_q;
  end

  // Divide both numerators by the span, one quotient bit per stage
  logic              dv_vld [FW+1];
  logic [RW-1:0]     dv_rx  [FW+1];
  logic [RW-1:0]     dv_ry  [FW+1];
  logic [FW-1:0]     dv_qx  [FW+1];
  logic [FW-1:0]     dv_qy  [FW+1];
  pds_pkg::mid_t     dv_mid [FW+1];

  assign dv_vld[0] = d_vld_q;
  assign dv_rx[0]  = d_nx_q;
  assign dv_ry[0]  = d_ny_q;
  assign dv_qx[0]  = '0;
  assign dv_qy[0]  = '0;
  assign dv_mid[0] = d_mid_q;

  for (genvar k = 0; k < FW; k++) begin : g_div
    logic [RW:0]   shx, shy;
    logic          gex, gey;
    logic          vld_q;
    logic [RW-1:0] rx_q, ry_q;
    logic [FW-1:0] qx_q, qy_q;
    pds_pkg::mid_t mid_q;

    assign shx = {dv_rx[k], 1'b0};
    assign shy = {dv_ry[k], 1'b0};
    assign gex = shx >= {1'b0, dv_mid[k].span};
    assign gey = shy >= {1'b0, dv_mid[k].span};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) vld_q <= 1'b0;
      else         vld_q <= dv_vld[k];
    end

    always_ff @(posedge clk_i) begin
      rx_q  <= gex ? RW'(shx - {1'b0, dv_mid[k].span}) : shx[RW-1:0];
      ry_q  <= gey ? RW'(shy - {1'b0, dv_mid[k].span}) : shy[RW-1:0];
      qx_q  <= {dv_qx[k][FW-2:0], gex};
      qy_q  <= {dv_qy[k][FW-2:0], gey};
      mid_q <= dv_mid[k];
    end

    assign dv_vld[k+1] = vld_q;
    assign dv_rx[k+1]  = rx_q;
    assign dv_ry[k+1]  = ry_q;
    assign dv_qx[k+1]  = qx_q;
    assign dv_qy[k+1]  = qy_q;
    assign dv_mid[k+1] = mid_q;
  end

  // M1: squares of x and y, denominator span * distance
  logic              m1_vld_q;
  logic [FW-1:0]     m1_x_q, m1_y_q, m1_x2_q, m1_y2_q;
  logic [DNW-1:0]    m1_den_q;
  pds_pkg::mid_t     m1_mid_q;
  logic [2*FW-1:0]   xx, yy;

  assign xx = (2*FW)'(dv_qx[FW]) * (2*FW)'(dv_qx[FW]);
  assign yy = (2*FW)'(dv_qy[FW]) * (2*FW)'(dv_qy[FW]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) m1_vld_q <= 1'b0;
    else         m1_vld_q <= dv_vld[FW];
  end

  always_ff @(posedge clk_i) begin
    m1_x_q   <= dv_qx[FW];
    m1_y_q   <= dv_qy[FW];
    m1_x2_q  <= xx[2*FW-1:FW];
    m1_y2_q  <= yy[2*FW-1:FW];
    m1_den_q <= DNW'(dv_mid[FW].span) * DNW'(dv_mid[FW].dlen);
    m1_mid_q <= dv_mid[FW];
  end

  // M2: cube of x, polynomial Y and product A
  logic              m2_vld_q;
  logic [FW-1:0]     m2_x2_q, m2_x3_q;
  logic [FW+3:0]     m2_yp_q;
  logic [FW+2:0]     m2_a_q;
  logic [DNW-1:0]    m2_den_q;
  pds_pkg::mid_t     m2_mid_q;
  logic [2*FW-1:0]   x3w;
  logic [FW+2:0]     fa;
  logic [2*FW+2:0]   aw;

  assign x3w = (2*FW)'(m1_x2_q) * (2*FW)'(m1_x_q);
  assign fa  = (FW+3)'(pds_pkg::ONE_Q30) + ((FW+3)'(m1_y_q) << 2);
  assign aw  = (2*FW+3)'(m1_x_q) * (2*FW+3)'(fa);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) m2_vld_q <= 1'b0;
    else         m2_vld_q <= m1_vld_q;
  end

  always_ff @(posedge clk_i) begin
    m2_x2_q  <= m1_x2_q;
    m2_x3_q  <= x3w[2*FW-1:FW];
    m2_yp_q  <= (FW+4)'(pds_pkg::ONE_Q30) + (FW+4)'(3) * (FW+4)'(m1_y_q)
                + (FW+4)'(6) * (FW+4)'(m1_y2_q);
    m2_a_q   <= aw[2*FW+2:FW];
    m2_den_q <= m1_den_q;
    m2_mid_q <= m1_mid_q;
  end

  // M3: switch value and sign and size of the polynomial difference
  logic              m3_vld_q;
  logic [FW-1:0]     m3_x2_q;
  logic [RW-1:0]     m3_sw_q;
  logic              m3_pneg_q;
  logic [FW+3:0]     m3_pm_q;
  logic [DNW-1:0]    m3_den_q;
  pds_pkg::mid_t     m3_mid_q;
  logic [2*FW+3:0]   sww;
  logic [FW+3:0]     swf;
  logic              pneg;

  assign sww  = (2*FW+4)'(m2_x3_q) * (2*FW+4)'(m2_yp_q);
  assign swf  = sww[2*FW+3:FW];
  assign pneg = (FW+4)'(m2_a_q) < m2_yp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) m3_vld_q <= 1'b0;
    else         m3_vld_q <= m2_vld_q;
  end

  always_ff @(posedge clk_i) begin
    m3_x2_q   <= m2_x2_q;
    m3_sw_q   <= (swf > (FW+4)'(pds_pkg::ONE_Q30)) ? pds_pkg::ONE_Q30 : swf[RW-1:0];
    m3_pneg_q <= pneg;
    m3_pm_q   <= pneg ? m2_yp_q - (FW+4)'(m2_a_q) : (FW+4)'(m2_a_q) - m2_yp_q;
    m3_den_q  <= m2_den_q;
    m3_mid_q  <= m2_mid_q;
  end

  // M4: scalar factor magnitude before the factor twelve
  logic              m4_vld_q;
  logic [FW+3:0]     m4_t_q;
  logic [DNW-1:0]    m4_den_q;
  pds_pkg::mid_t     m4_mid_q;
  pds_pkg::tail_t    m4_tail_q;
  logic [2*FW+3:0]   tw;

  assign tw = (2*FW+4)'(m3_x2_q) * (2*FW+4)'(m3_pm_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) m4_vld_q <= 1'b0;
    else         m4_vld_q <= m3_vld_q;
  end

  always_ff @(posedge clk_i) begin
    m4_t_q              <= tw[2*FW+3:FW];
    m4_den_q            <= m3_den_q;
    m4_mid_q            <= m3_mid_q;
    m4_tail_q.inner_hit <= m3_mid_q.inner_hit;
    m4_tail_q.blend     <= m3_mid_q.blend;
    m4_tail_q.pneg      <= m3_pneg_q;
    m4_tail_q.sw        <= m3_sw_q;
    m4_tail_q.neg       <= m3_mid_q.vec.neg;
    m4_tail_q.ovf       <= '0;
  end

  // M5: gradient numerators, 12 * t * |r|
  logic                 m5_vld_q;
  logic [2:0][NMW-1:0]  m5_num_q;
  logic [DNW-1:0]       m5_den_q;
  pds_pkg::tail_t       m5_tail_q;
  logic [2:0][NMW-1:0]  prod;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      prod[i] = NMW'((FW+4+RW)'(m4_t_q) * (FW+4+RW)'(m4_mid_q.vec.mag[i]));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) m5_vld_q <= 1'b0;
    else         m5_vld_q <= m4_vld_q;
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      m5_num_q[i] <= (prod[i] << 3) + (prod[i] << 2);
    end
    m5_den_q  <= m4_den_q;
    m5_tail_q <= m4_tail_q;
  end

  // M6: overflow check and divider setup
  logic                 gd_vld  [QG+1];
  logic [2:0][DNW-1:0]  gd_rem  [QG+1];
  logic [2:0][QG-1:0]   gd_low  [QG+1];
  logic [2:0][QG-1:0]   gd_quo  [QG+1];
  logic [DNW-1:0]       gd_den  [QG+1];
  pds_pkg::tail_t       gd_tail [QG+1];

  logic                 m6_vld_q;
  logic [2:0][DNW-1:0]  m6_rem_q;
  logic [2:0][QG-1:0]   m6_low_q;
  logic [DNW-1:0]       m6_den_q;
  pds_pkg::tail_t       m6_tail_q;
  pds_pkg::tail_t       m6_tail_d;
  logic [2:0]           ovf;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ovf[i] = DNW'(m5_num_q[i][NMW-1:QG]) >= m5_den_q;
    end
    m6_tail_d     = m5_tail_q;
    m6_tail_d.ovf = ovf;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) m6_vld_q <= 1'b0;
    else         m6_vld_q <= m5_vld_q;
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      m6_rem_q[i] <= DNW'(m5_num_q[i][NMW-1:QG]);
      m6_low_q[i] <= m5_num_q[i][QG-1:0];
    end
    m6_den_q  <= m5_den_q;
    m6_tail_q <= m6_tail_d;
  end

  assign gd_vld[0]  = m6_vld_q;
  assign gd_rem[0]  = m6_rem_q;
  assign gd_low[0]  = m6_low_q;
  assign gd_quo[0]  = '0;
  assign gd_den[0]  = m6_den_q;
  assign gd_tail[0] = m6_tail_q;

  // Gradient divider, one quotient bit per stage in each lane
  for (genvar k = 0; k < QG; k++) begin : g_gdiv
    logic [2:0][DNW:0]    sh;
    logic [2:0]           ge;
    logic                 vld_q;
    logic [2:0][DNW-1:0]  rem_q;
    logic [2:0][QG-1:0]   low_q, quo_q;
    logic [DNW-1:0]       den_q;
    pds_pkg::tail_t       tail_q;

    always_comb begin
      for (int i = 0; i < 3; i++) begin
        sh[i] = {gd_rem[k][i], gd_low[k][i][QG-1]};
        ge[i] = sh[i] >= {1'b0, gd_den[k]};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) vld_q <= 1'b0;
      else         vld_q <= gd_vld[k];
    end

    always_ff @(posedge clk_i) begin
      for (int i = 0; i < 3; i++) begin
        rem_q[i] <= ge[i] ? DNW'(sh[i] - {1'b0, gd_den[k]}) : sh[i][DNW-1:0];
        low_q[i] <= gd_low[k][i] << 1;
        quo_q[i] <= {gd_quo[k][i][QG-2:0], ge[i]};
      end
      den_q  <= gd_den[k];
      tail_q <= gd_tail[k];
    end

    assign gd_vld[k+1]  = vld_q;
    assign gd_rem[k+1]  = rem_q;
    assign gd_low[k+1]  = low_q;
    assign gd_quo[k+1]  = quo_q;
    assign gd_den[k+1]  = den_q;
    assign gd_tail[k+1] = tail_q;
  end

  // Output stage: saturate, apply signs, pick the region result
  logic [2:0][pds_pkg::GRAD_W-1:0] grad_d;
  logic [pds_pkg::RADIUS_W-1:0]    sw_d;
  pds_pkg::tail_t                  ft;
  logic                            done_q;
  logic [pds_pkg::RADIUS_W-1:0]    sw_q;
  logic [2:0][pds_pkg::GRAD_W-1:0] grad_q;

  assign ft = gd_tail[QG];

  always_comb begin
    logic [QG-1:0]             q;
    logic                      gneg;
    logic                      sat_p, sat_n;
    logic [pds_pkg::GRAD_W-1:0] m;
    for (int i = 0; i < 3; i++) begin
      q     = gd_quo[QG][i];
      gneg  = ft.pneg != ft.neg[i];
      sat_p = ft.ovf[i] || (q[QG-1:QG-2] != 2'b00);
      sat_n = ft.ovf[i] || q[QG-1] || (q[QG-2] && (q[QG-3:0] != '0));
      m     = '0;
      if (!ft.blend) begin
        grad_d[i] = '0;
      end else if (gneg) begin
        m         = sat_n ? (pds_pkg::GRAD_W'(1) << (pds_pkg::GRAD_W - 1))
                          : q[pds_pkg::GRAD_W-1:0];
        grad_d[i] = pds_pkg::GRAD_W'(0) - m;
      end else begin
        grad_d[i] = sat_p ? {1'b0, {(pds_pkg::GRAD_W-1){1'b1}}} : q[pds_pkg::GRAD_W-1:0];
      end
    end
    if (ft.inner_hit)  sw_d = pds_pkg::ONE_Q30;
    else if (ft.blend) sw_d = ft.sw;
    else               sw_d = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) done_q <= 1'b0;
    else         done_q <= gd_vld[QG];
  end

  always_ff @(posedge clk_i) begin
    sw_q   <= sw_d;
    grad_q <= grad_d;
  end

  assign done_o         = done_q;
  assign switch_value_o = sw_q;
  assign grad_x_o       = grad_q[0];
  assign grad_y_o       = grad_q[1];
  assign grad_z_o       = grad_q[2];

endmodule
`default_nettype wire

// ----- verif/pair_distance_switch_checker.sv -----
// Checker: tracks radius writes, predicts each item's switch result and compares.
`timescale 1ns / 100ps
module pair_distance_switch_checker (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              start_i,
  input  wire logic                              busy_i,
  input  wire logic signed [31:0]                first_x_i,
  input  wire logic signed [31:0]                first_y_i,
  input  wire logic signed [31:0]                first_z_i,
  input  wire logic signed [31:0]                second_x_i,
  input  wire logic signed [31:0]                second_y_i,
  input  wire logic signed [31:0]                second_z_i,
  input  wire logic                              done_i,
  input  wire logic [pds_pkg::RADIUS_W-1:0]      switch_value_i,
  input  wire logic signed [pds_pkg::GRAD_W-1:0] grad_x_i,
  input  wire logic signed [pds_pkg::GRAD_W-1:0] grad_y_i,
  input  wire logic signed [pds_pkg::GRAD_W-1:0] grad_z_i,
  input  wire logic                              cfg_valid_i,
  input  wire logic                              cfg_ready_i,
  input  wire logic [pds_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  wire logic [pds_pkg::RADIUS_W-1:0]      cfg_data_i,
  output int                                     fail_count_o,
  output int                                     pending_o
);

  typedef struct {
    logic [pds_pkg::RADIUS_W-1:0]      sw;
    logic signed [pds_pkg::GRAD_W-1:0] g [3];
  } switch_result_t;

  logic [pds_pkg::RADIUS_W-1:0] inner_q, outer_q;
  switch_result_t               expected_q [$];

  // Scale the gradient magnitude by one component, apply its sign and saturate.
  function automatic logic [pds_pkg::GRAD_W-1:0] grad_component(logic [127:0] mag4,
                                                                longint comp, bit p_neg,
                                                                logic [127:0] den);
    logic [127:0] cm, q;
    bit           neg;
    cm  = (comp < 0) ? 128'(-comp) : 128'(comp);
    q   = (mag4 * cm) / den;
    neg = p_neg != (comp < 0);
    if (q == 0) return '0;
    if (neg) begin
      if (q > 128'h8000_0000) q = 128'h8000_0000;
      return pds_pkg::GRAD_W'(-q);
    end
    if (q > 128'h7FFF_FFFF) q = 128'h7FFF_FFFF;
    return pds_pkg::GRAD_W'(q);
  endfunction

  // Compute the switch factor and gradient of one position pair.
  function automatic switch_result_t predict_switch(logic signed [31:0] fc [3],
                                                    logic signed [31:0] sc [3]);
    switch_result_t res;
    longint         r [3];
    logic [127:0]   sum, mag, d, cand, inn, out, spn, x, y, x2, x3, y2, yy, aa, pm, sw;
    logic [127:0]   mag4, den;
    bit             p_neg;
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      r[i] = longint'(fc[i]) - longint'(sc[i]);
      mag  = (r[i] < 0) ? 128'(-r[i]) : 128'(r[i]);
      sum  = sum + mag * mag;
    end
    d = 0;
    for (int b = 50; b >= 0; b--) begin
      cand = d | (128'd1 << b);
      if (cand * cand <= sum) d = cand;
    end
    inn = 128'(inner_q);
    out = 128'(outer_q);
    res.sw = pds_pkg::ONE_Q30;
    for (int i = 0; i < 3; i++) res.g[i] = '0;
    if (d <= inn) return res;
    res.sw = '0;
    if (d >= out) return res;
    // Blend region between the radii
    spn = out - inn;
    x   = ((out - d) << 30) / spn;
    y   = ((d - inn) << 30) / spn;
    x2  = (x * x) >> 30;
    x3  = (x2 * x) >> 30;
    y2  = (y * y) >> 30;
    yy  = (128'd1 << 30) + 3 * y + 6 * y2;
    sw  = (x3 * yy) >> 30;
    res.sw = (sw > (128'd1 << 30)) ? pds_pkg::ONE_Q30 : pds_pkg::RADIUS_W'(sw);
    aa    = (x * ((128'd1 << 30) + 4 * y)) >> 30;
    p_neg = aa < yy;
    pm    = p_neg ? yy - aa : aa - yy;
    mag4  = 12 * ((x2 * pm) >> 30);
    den   = spn * d;
    for (int i = 0; i < 3; i++) res.g[i] = grad_component(mag4, r[i], p_neg, den);
    return res;
  endfunction

  assign pending_o = expected_q.size();

  // Mirror register writes, queue predictions, check each result strobe.
  always @(posedge clk_i or negedge rst_ni) begin
    logic signed [31:0] fc [3];
    logic signed [31:0] sc [3];
    switch_result_t     exp_r;
    logic signed [pds_pkg::GRAD_W-1:0] act [3];
    int                 errs;
    errs = 0;
    if (!rst_ni) begin
      inner_q      <= pds_pkg::INNER_RESET;
      outer_q      <= pds_pkg::OUTER_RESET;
      fail_count_o <= 0;
      expected_q.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == pds_pkg::CFG_INNER) inner_q <= cfg_data_i;
        else if (cfg_index_i == pds_pkg::CFG_OUTER) outer_q <= cfg_data_i;
      end
      if (start_i && !busy_i) begin
        fc = '{first_x_i, first_y_i, first_z_i};
        sc = '{second_x_i, second_y_i, second_z_i};
        expected_q.push_back(predict_switch(fc, sc));
      end
      if (done_i) begin
        if (expected_q.size() == 0) begin
          $display("%0t: result with nothing expected: sw %0d", $time, switch_value_i);
          errs++;
        end else begin
          exp_r = expected_q.pop_front();
          act   = '{grad_x_i, grad_y_i, grad_z_i};
          if (exp_r.sw !== switch_value_i) begin
            $display("%0t: switch_value expected %0d actual %0d", $time, exp_r.sw,
                     switch_value_i);
            errs++;
          end
          for (int i = 0; i < 3; i++)
            if (exp_r.g[i] !== act[i]) begin
              $display("%0t: grad[%0d] expected %0d actual %0d", $time, i, exp_r.g[i],
                       act[i]);
              errs++;
            end
        end
      end
      if (errs != 0) fail_count_o <= fail_count_o + errs;
    end
  end

endmodule

// ----- verif/pair_distance_switch_tb.sv -----
// Testbench top: drives items and radius writes, gives the verdict.
`timescale 1ns / 100ps
module pair_distance_switch_tb;

  localparam logic [pds_pkg::CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [pds_pkg::CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;
  localparam int                   STALL_LIMIT  = 3000;
  localparam logic [30:0]          RADIUS_MAX   = 31'h7FFF_FFFF;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic signed [31:0] first_x_i = '0, first_y_i = '0, first_z_i = '0;
  logic signed [31:0] second_x_i = '0, second_y_i = '0, second_z_i = '0;
  logic cfg_valid_i = 1'b0;
  logic [pds_pkg::CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [pds_pkg::RADIUS_W-1:0]  cfg_data_i = '0;
  logic busy_o, done_o, cfg_ready_o;
  logic [pds_pkg::RADIUS_W-1:0] switch_value_o;
  logic signed [pds_pkg::GRAD_W-1:0] grad_x_o, grad_y_o, grad_z_o;
  int fail_count, pending, idle_cycles;
  logic [30:0] inner_r = pds_pkg::INNER_RESET, outer_r = pds_pkg::OUTER_RESET;

  always #5 clk_i = ~clk_i;

  pair_distance_switch dut (.*);

  pair_distance_switch_checker checker_i (
    .clk_i, .rst_ni, .start_i, .busy_i(busy_o),
    .first_x_i, .first_y_i, .first_z_i, .second_x_i, .second_y_i, .second_z_i,
    .done_i(done_o), .switch_value_i(switch_value_o),
    .grad_x_i(grad_x_o), .grad_y_i(grad_y_o), .grad_z_i(grad_z_o),
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // Watchdog: end the run when no transfer happens for too long.
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || done_o || (cfg_valid_i && cfg_ready_o) || !rst_ni)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("pair_distance_switch verification failed");
      $finish;
    end
  end

  // Present one pair and hold it until the transfer.
  task automatic send_pair(longint fx, longint fy, longint fz,
                           longint sx, longint sy, longint sz);
    start_i    <= 1'b1;
    first_x_i  <= 32'(fx);
    first_y_i  <= 32'(fy);
    first_z_i  <= 32'(fz);
    second_x_i <= 32'(sx);
    second_y_i <= 32'(sy);
    second_z_i <= 32'(sz);
    do @(posedge clk_i); while (busy_o);
  endtask

  // Send a pair whose difference vector is given, centered on a random base.
  task automatic send_diff(longint dx, longint dy, longint dz);
    longint bx, by, bz;
    bx = longint'($urandom_range(0, 32'h4000_0000)) - 64'h2000_0000;
    by = longint'($urandom_range(0, 32'h4000_0000)) - 64'h2000_0000;
    bz = longint'($urandom_range(0, 32'h4000_0000)) - 64'h2000_0000;
    send_pair(bx + dx / 2, by + dy / 2, bz + dz / 2,
              bx - (dx - dx / 2), by - (dy - dy / 2), bz - (dz - dz / 2));
  endtask

  task automatic pause_sender(int cycles);
    start_i <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  // Drain the pipeline, then write one register.
  task automatic write_radius(logic [pds_pkg::CFG_IDX_W-1:0] idx, logic [30:0] value);
    start_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == pds_pkg::CFG_INNER) inner_r = value;
    else if (idx == pds_pkg::CFG_OUTER) outer_r = value;
  endtask

  task automatic set_radii(logic [30:0] inner_v, logic [30:0] outer_v);
    write_radius(pds_pkg::CFG_INNER, inner_v);
    write_radius(pds_pkg::CFG_OUTER, outer_v);
  endtask

  // Extremes and boundary distances for the current radii.
  task automatic directed_pairs();
    longint m;
    m = longint'(inner_r);
    send_pair(0, 0, 0, 0, 0, 0);
    send_pair(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
              -64'h8000_0000, -64'h8000_0000, -64'h8000_0000);
    send_pair(-64'h8000_0000, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, -1, -64'h8000_0000);
    send_pair(-1, -1, -1, 0, 0, 0);
    send_diff(m, 0, 0);
    send_diff(0, -m - 1, 0);
    send_diff(0, 0, longint'(outer_r));
    send_diff(-longint'(outer_r) + 1, 0, 0);
    send_diff((m + longint'(outer_r)) / 2, 0, 0);
    send_diff(0, -(m + longint'(outer_r)) / 2, 0);
    send_diff(0, 0, -(m + longint'(outer_r)) / 2);
    send_diff((m + longint'(outer_r)) / 3, -(m + longint'(outer_r)) / 3,
              (m + longint'(outer_r)) / 3);
  endtask

  // Random pairs in bursts, mostly near the blend region.
  task automatic random_pairs(int count);
    int     burst;
    longint t;
    burst = $urandom_range(1, 20);
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 3) == 0) begin
        send_pair($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      end else begin
        t = longint'(outer_r) + longint'(outer_r) / 4 + 1;
        if (t > 64'h4000_0000) t = 64'h4000_0000;
        t = longint'($urandom_range(0, 32'(t)));
        send_diff(longint'($urandom_range(0, 32'(2 * t))) - t,
                  longint'($urandom_range(0, 32'(2 * t))) - t,
                  longint'($urandom_range(0, 32'(2 * t))) - t);
      end
      if (--burst == 0) begin
        burst = $urandom_range(1, 20);
        if ($urandom_range(0, 3) != 0) pause_sender($urandom_range(1, 8));
      end
    end
    start_i <= 1'b0;
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // Reset radii first
    directed_pairs();
    random_pairs(200);
    // Ignored register indexes must leave the radii alone
    write_radius(CFG_SPARE_LO, 31'($urandom));
    write_radius(CFG_SPARE_HI, 31'($urandom));
    random_pairs(50);
    // Tiny span saturates the gradient
    set_radii(31'd100, 31'd103);
    directed_pairs();
    random_pairs(100);
    set_radii(31'd0, 31'd40000);
    directed_pairs();
    random_pairs(150);
    // Inner not below outer: never blends
    set_radii(RADIUS_MAX, 31'd0);
    directed_pairs();
    random_pairs(50);
    set_radii(31'd0, RADIUS_MAX);
    directed_pairs();
    random_pairs(150);
    set_radii(31'd300000, 31'd310000);
    random_pairs(100);
    for (int k = 0; k < 2; k++) begin
      set_radii(31'($urandom_range(0, 32'h0100_0000)),
                31'h0100_0000 + 31'($urandom_range(1, 32'h0400_0000)));
      random_pairs(100);
    end
    start_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (150) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("pair_distance_switch verification clean");
    end else begin
      $display("pair_distance_switch verification failed");
    end
    $finish;
  end

endmodule
